FILE: hdl/prrs_pkg.sv
`default_nettype none
package prrs_pkg;
    localparam int MAX_JOBS = 16;
    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    localparam logic [7:0] QUANTUM_RESET = 8'd4;

    typedef enum logic {
        CFG_HIGH_QUANTUM = 1'b0,
        CFG_LOW_QUANTUM  = 1'b1
    } cfg_index_t;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_RR_ROT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] rem;
        logic [15:0] seq;
    } prio_slot_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] rem;
    } rr_slot_t;

    function automatic logic [7:0] eff_q(input logic [7:0] q);
        eff_q = (q == 8'd0) ? 8'd1 : q;
    endfunction

    // Entry a beats entry b: lower priority, or equal priority and older stamp.
    function automatic logic beats(input prio_slot_t a, input prio_slot_t b);
        logic [15:0] d;
        d = b.seq - a.seq;
        beats = (a.prio < b.prio) ||
                ((a.prio == b.prio) && (d != 16'd0) && !d[15]);
    endfunction
endpackage
`default_nettype wire

FILE: hdl/priority_rr_two_level_scheduler_top.sv
`default_nettype none
// Two-level job scheduler: a preemptive priority store (lowest value first,
// ties in arrival order) in front of a round-robin FIFO. Pulse start with
// command 0 to submit a job or command 1 for one time tick; busy stays high
// while the transaction is worked, and the next one can be accepted in the
// cycle after done. The priority store is walked one slot per cycle by a
// single compare unit to find the best job, the free slot and the job count,
// then the act state applies the update, the rotate state finishes a
// round-robin move through the single FIFO port, and done pulses with the
// result fields for one cycle. The receiver cannot stall; results must be
// taken on the done pulse.
// Quantum registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle (the block itself does not enforce it);
// a write reloads the matching ticks-left counter, and zero acts as one.
module priority_rr_two_level_scheduler_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [15:0] job_id,
    input  wire logic [7:0]  job_priority,
    input  wire logic [15:0] job_burst,
    output logic             done,
    output logic             ran_valid,
    output logic [15:0]      ran_id,
    output logic             ran_finished,
    output logic             arrival_rejected
);
    localparam int IW = prrs_pkg::IDX_W;
    localparam int CW = prrs_pkg::CNT_W;

    prrs_pkg::state_t state_reg, state_next;

    // Priority store: valid bits in flops, payload in a register array
    // read at the scan index and written at one index.
    logic [prrs_pkg::MAX_JOBS-1:0] pvalid_reg;
    prrs_pkg::prio_slot_t          pmem [prrs_pkg::MAX_JOBS];
    prrs_pkg::rr_slot_t            rmem [prrs_pkg::MAX_JOBS];

    logic [7:0]    hq_reg, lq_reg, hleft_reg, lleft_reg;
    logic [15:0]   seq_reg;
    logic [IW-1:0] rhead_reg;
    logic [CW-1:0] rcount_reg;
    logic [IW:0]   scan_reg;

    logic          cmd_reg;
    logic [15:0]   jid_reg, jburst_reg;
    logic [7:0]    jprio_reg;

    logic          o_valid_reg, o_fin_reg, o_rej_reg;
    logic [15:0]   o_id_reg;

    // Pending FIFO work after the act cycle
    logic          rot_pend_reg;   // rotate head to tail
    logic          dem_pend_reg;   // push expired priority job to tail
    prrs_pkg::rr_slot_t rr_head_q; // registered FIFO head read

    prrs_pkg::prio_slot_t slot_rd;
    logic                 scan_step, scan_clear;
    logic                 best_found, free_found;
    logic [IW-1:0]        best_idx, free_idx;
    prrs_pkg::prio_slot_t best_slot;
    logic [CW-1:0]        pcount;

    always_comb
    begin
        slot_rd       = pmem[scan_reg[IW-1:0]];
        slot_rd.valid = pvalid_reg[scan_reg[IW-1:0]];
    end

    assign scan_clear = (state_reg == prrs_pkg::ST_IDLE);
    assign scan_step  = (state_reg == prrs_pkg::ST_SCAN);

    prrs_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (scan_clear),
        .step       (scan_step),
        .idx        (scan_reg[IW-1:0]),
        .slot       (slot_rd),
        .best_found (best_found),
        .best_idx   (best_idx),
        .best_slot  (best_slot),
        .free_found (free_found),
        .free_idx   (free_idx),
        .count      (pcount)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prrs_pkg::ST_IDLE:
                if (start)
                    state_next = prrs_pkg::ST_SCAN;
            prrs_pkg::ST_SCAN:
                if (scan_reg == (IW+1)'(prrs_pkg::MAX_JOBS - 1))
                    state_next = prrs_pkg::ST_ACT;
            prrs_pkg::ST_ACT:
                state_next = prrs_pkg::ST_RR_ROT;
            prrs_pkg::ST_RR_ROT:
                state_next = prrs_pkg::ST_DONE;
            prrs_pkg::ST_DONE:
                state_next = prrs_pkg::ST_IDLE;
            default:
                state_next = prrs_pkg::ST_IDLE;
        endcase
    end

    // Output decode
    always_comb
    begin
        busy = (state_reg != prrs_pkg::ST_IDLE);
        done = (state_reg == prrs_pkg::ST_DONE);
    end

    assign ran_valid        = o_valid_reg;
    assign ran_id           = o_id_reg;
    assign ran_finished     = o_fin_reg;
    assign arrival_rejected = o_rej_reg;

    // FIFO tail index
    logic [IW:0]   tail_sum;
    logic [IW-1:0] tail_idx;
    logic [IW-1:0] head_inc;
    always_comb
    begin
        tail_sum = {1'b0, rhead_reg} + (IW+1)'(rcount_reg);
        tail_idx = (tail_sum >= (IW+1)'(prrs_pkg::MAX_JOBS))
                 ? IW'(tail_sum - (IW+1)'(prrs_pkg::MAX_JOBS)) : tail_sum[IW-1:0];
        head_inc = (rhead_reg == IW'(prrs_pkg::MAX_JOBS - 1)) ? '0 : rhead_reg + 1'b1;
    end

    logic [7:0] hq_eff, lq_eff;
    assign hq_eff = prrs_pkg::eff_q(hq_reg);
    assign lq_eff = prrs_pkg::eff_q(lq_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= prrs_pkg::ST_IDLE;
            pvalid_reg   <= '0;
            hq_reg       <= prrs_pkg::QUANTUM_RESET;
            lq_reg       <= prrs_pkg::QUANTUM_RESET;
            hleft_reg    <= prrs_pkg::QUANTUM_RESET;
            lleft_reg    <= prrs_pkg::QUANTUM_RESET;
            seq_reg      <= '0;
            rhead_reg    <= '0;
            rcount_reg   <= '0;
            scan_reg     <= '0;
            rot_pend_reg <= 1'b0;
            dem_pend_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            o_fin_reg    <= 1'b0;
            o_rej_reg    <= 1'b0;
            o_id_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    prrs_pkg::CFG_HIGH_QUANTUM:
                    begin
                        hq_reg    <= cfg_data;
                        hleft_reg <= prrs_pkg::eff_q(cfg_data);
                    end
                    prrs_pkg::CFG_LOW_QUANTUM:
                    begin
                        lq_reg    <= cfg_data;
                        lleft_reg <= prrs_pkg::eff_q(cfg_data);
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                prrs_pkg::ST_IDLE:
                begin
                    scan_reg     <= '0;
                    rot_pend_reg <= 1'b0;
                    dem_pend_reg <= 1'b0;
                end
                prrs_pkg::ST_SCAN:
                    scan_reg <= scan_reg + 1'b1;
                prrs_pkg::ST_ACT:
                begin
                    o_valid_reg <= 1'b0;
                    o_fin_reg   <= 1'b0;
                    o_rej_reg   <= 1'b0;
                    o_id_reg    <= '0;
                    if (cmd_reg == prrs_pkg::CMD_ARRIVE)
                    begin
                        if ((CW+1)'(pcount) + (CW+1)'(rcount_reg)
                            >= (CW+1)'(prrs_pkg::MAX_JOBS))
                            o_rej_reg <= 1'b1;
                        else
                        begin
                            if (best_found && hleft_reg != hq_eff &&
                                jprio_reg < best_slot.prio)
                            begin
                                // Demote running job; arrival takes its slot
                                pvalid_reg[best_idx] <= 1'b1;
                                rcount_reg           <= rcount_reg + 1'b1;
                                hleft_reg            <= hq_eff;
                            end
                            else
                                pvalid_reg[free_idx] <= 1'b1;
                            seq_reg <= seq_reg + 1'b1;
                        end
                    end
                    else if (best_found)
                    begin
                        o_valid_reg <= 1'b1;
                        o_id_reg    <= best_slot.id;
                        // Partly served FIFO head goes to the tail first;
                        // an expiring priority job lands behind it next cycle
                        if (lleft_reg != lq_eff && rcount_reg != '0)
                        begin
                            rhead_reg <= head_inc;
                            lleft_reg <= lq_eff;
                        end
                        if (best_slot.rem <= 16'd1)
                        begin
                            pvalid_reg[best_idx] <= 1'b0;
                            o_fin_reg            <= 1'b1;
                            hleft_reg            <= hq_eff;
                        end
                        else if (hleft_reg <= 8'd1)
                        begin
                            pvalid_reg[best_idx] <= 1'b0;
                            dem_pend_reg         <= 1'b1;
                            hleft_reg            <= hq_eff;
                        end
                        else
                            hleft_reg <= hleft_reg - 1'b1;
                    end
                    else if (rcount_reg != '0)
                    begin
                        o_valid_reg <= 1'b1;
                        o_id_reg    <= rr_head_q.id;
                        if (rr_head_q.rem <= 16'd1)
                        begin
                            rhead_reg  <= head_inc;
                            rcount_reg <= rcount_reg - 1'b1;
                            o_fin_reg  <= 1'b1;
                            lleft_reg  <= lq_eff;
                        end
                        else if (lleft_reg <= 8'd1)
                        begin
                            rot_pend_reg <= 1'b1;
                            lleft_reg    <= lq_eff;
                        end
                        else
                            lleft_reg <= lleft_reg - 1'b1;
                    end
                end
                prrs_pkg::ST_RR_ROT:
                begin
                    if (rot_pend_reg)
                        rhead_reg <= head_inc;
                    if (dem_pend_reg)
                        rcount_reg <= rcount_reg + 1'b1;
                end
                prrs_pkg::ST_DONE: ;
                default: ;
            endcase
        end
    end

    // Payload: transaction capture, stores, registered FIFO head read.
    // Rotation with the FIFO full writes the head back over itself, which
    // is the same slot as the tail.
    always_ff @(posedge clk)
    begin
        if (state_reg == prrs_pkg::ST_IDLE && start)
        begin
            cmd_reg    <= command;
            jid_reg    <= job_id;
            jprio_reg  <= job_priority;
            jburst_reg <= job_burst;
        end
        rr_head_q <= rmem[rhead_reg];
        if (state_reg == prrs_pkg::ST_ACT)
        begin
            if (cmd_reg == prrs_pkg::CMD_ARRIVE)
            begin
                if ((CW+1)'(pcount) + (CW+1)'(rcount_reg)
                    < (CW+1)'(prrs_pkg::MAX_JOBS))
                begin
                    if (best_found && hleft_reg != hq_eff &&
                        jprio_reg < best_slot.prio)
                    begin
                        rmem[tail_idx]  <= '{id: best_slot.id, rem: best_slot.rem};
                        pmem[best_idx]  <= '{valid: 1'b1, id: jid_reg, prio: jprio_reg,
                                             rem: jburst_reg, seq: seq_reg};
                    end
                    else
                        pmem[free_idx] <= '{valid: 1'b1, id: jid_reg, prio: jprio_reg,
                                            rem: jburst_reg, seq: seq_reg};
                end
            end
            else if (best_found)
            begin
                if (best_slot.rem > 16'd1)
                    pmem[best_idx].rem <= best_slot.rem - 1'b1;
                if (lleft_reg != lq_eff && rcount_reg != '0)
                    rmem[tail_idx] <= rr_head_q;
            end
            else if (rcount_reg != '0 && rr_head_q.rem > 16'd1)
                rmem[rhead_reg].rem <= rr_head_q.rem - 1'b1;
        end
        else if (state_reg == prrs_pkg::ST_RR_ROT)
        begin
            // Head read predates the act-cycle decrement
            if (rot_pend_reg)
                rmem[tail_idx] <= '{id: rr_head_q.id, rem: rr_head_q.rem - 16'd1};
            else if (dem_pend_reg)
                rmem[tail_idx] <= '{id: best_slot.id, rem: best_slot.rem - 16'd1};
        end
    end
endmodule
`default_nettype wire

FILE: hdl/prrs_scan.sv
`default_nettype none
// Sequential best-slot and free-slot search over the priority store,
// one slot per cycle through a shared compare.
module prrs_scan
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     clear,
    input  wire logic                     step,
    input  wire logic [prrs_pkg::IDX_W-1:0] idx,
    input  wire prrs_pkg::prio_slot_t     slot,
    output logic                          best_found,
    output logic [prrs_pkg::IDX_W-1:0]    best_idx,
    output prrs_pkg::prio_slot_t          best_slot,
    output logic                          free_found,
    output logic [prrs_pkg::IDX_W-1:0]    free_idx,
    output logic [prrs_pkg::CNT_W-1:0]    count
);
    logic                        best_found_reg, best_found_next;
    logic [prrs_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;
    prrs_pkg::prio_slot_t        best_slot_reg, best_slot_next;
    logic                        free_found_reg, free_found_next;
    logic [prrs_pkg::IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [prrs_pkg::CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_slot_next  = best_slot_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        if (clear)
        begin
            best_found_next = 1'b0;
            free_found_next = 1'b0;
            count_next      = '0;
        end
        else if (step)
        begin
            if (slot.valid)
            begin
                count_next = count_reg + 1'b1;
                if (!best_found_reg || prrs_pkg::beats(slot, best_slot_reg))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = idx;
                    best_slot_next  = slot;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_slot_reg <= best_slot_next;
        free_idx_reg  <= free_idx_next;
    end

    assign best_found = best_found_reg;
    assign best_idx   = best_idx_reg;
    assign best_slot  = best_slot_reg;
    assign free_found = free_found_reg;
    assign free_idx   = free_idx_reg;
    assign count      = count_reg;
endmodule
`default_nettype wire

FILE: verif/tb_priority_rr_two_level_scheduler_top.sv
`timescale 1ns / 1ps
module tb_priority_rr_two_level_scheduler_top;

    // Clock, reset and block ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    logic        start = 1'b0;
    logic        busy;
    logic        command = prrs_pkg::CMD_TICK;
    logic [15:0] job_id = 16'd0;
    logic [7:0]  job_priority = 8'd0;
    logic [15:0] job_burst = 16'd0;
    logic        done;
    logic        ran_valid;
    logic [15:0] ran_id;
    logic        ran_finished;
    logic        arrival_rejected;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    priority_rr_two_level_scheduler_top i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .job_id           (job_id),
        .job_priority     (job_priority),
        .job_burst        (job_burst),
        .done             (done),
        .ran_valid        (ran_valid),
        .ran_id           (ran_id),
        .ran_finished     (ran_finished),
        .arrival_rejected (arrival_rejected)
    );

    // One scheduler outcome per transaction
    typedef struct packed {
        logic        run;
        logic [15:0] id;
        logic        fin;
        logic        rej;
    } sched_out_t;

    // Stimulus table row; chk marks rows whose outcome is typed in directly
    typedef struct {
        logic        cmd;
        logic [15:0] id;
        logic [7:0]  pr;
        logic [15:0] bu;
        bit          chk;
        sched_out_t  want;
    } job_row_t;

    sched_out_t pending_runs[$];
    int         n_errors = 0;
    int         n_results = 0;
    int         n_finished = 0;
    int         n_rejected = 0;
    int         n_sent = 0;
    int         cycle_cnt = 0;

    // ------------------------------------------------------------------
    // Scheduler shadow state
    // ------------------------------------------------------------------
    prrs_pkg::prio_slot_t hp_slot[prrs_pkg::MAX_JOBS];
    logic [15:0] fifo_id[prrs_pkg::MAX_JOBS];
    logic [15:0] fifo_rem[prrs_pkg::MAX_JOBS];
    int          fifo_head;
    int          fifo_cnt;
    logic [15:0] next_stamp;
    logic [7:0]  hq_reg;
    logic [7:0]  lq_reg;
    logic [7:0]  hq_left;
    logic [7:0]  lq_left;

    // A zero quantum behaves as one
    function automatic logic [7:0] quantum_of(input logic [7:0] q);
        return (q == 8'd0) ? 8'd1 : q;
    endfunction

    function automatic void shadow_reset();
        foreach (hp_slot[i])
            hp_slot[i] = '0;
        fifo_head  = 0;
        fifo_cnt   = 0;
        next_stamp = 16'd0;
        hq_reg     = prrs_pkg::QUANTUM_RESET;
        lq_reg     = prrs_pkg::QUANTUM_RESET;
        hq_left    = prrs_pkg::QUANTUM_RESET;
        lq_left    = prrs_pkg::QUANTUM_RESET;
    endfunction

    function automatic void shadow_cfg(input logic idx, input logic [7:0] val);
        if (idx == prrs_pkg::CFG_HIGH_QUANTUM)
        begin
            hq_reg  = val;
            hq_left = quantum_of(val);
        end
        else
        begin
            lq_reg  = val;
            lq_left = quantum_of(val);
        end
    endfunction

    // Best priority entry: lowest value, ties to the older stamp (mod 2^16)
    function automatic int best_hp();
        int          sel;
        logic [15:0] d;
        sel = -1;
        for (int i = 0; i < prrs_pkg::MAX_JOBS; i++)
        begin
            if (!hp_slot[i].valid)
                continue;
            d = hp_slot[sel < 0 ? i : sel].seq - hp_slot[i].seq;
            if (sel < 0 || hp_slot[i].prio < hp_slot[sel].prio ||
                (hp_slot[i].prio == hp_slot[sel].prio && d != 16'd0 && !d[15]))
                sel = i;
        end
        return sel;
    endfunction

    function automatic void fifo_push(input logic [15:0] id, input logic [15:0] rem);
        int t;
        if (fifo_cnt >= prrs_pkg::MAX_JOBS)
            return;
        t = (fifo_head + fifo_cnt) % prrs_pkg::MAX_JOBS;
        fifo_id[t]  = id;
        fifo_rem[t] = rem;
        fifo_cnt++;
    endfunction

    function automatic void fifo_pop();
        if (fifo_cnt == 0)
            return;
        fifo_head = (fifo_head + 1) % prrs_pkg::MAX_JOBS;
        fifo_cnt--;
    endfunction

    function automatic void fifo_rotate();
        logic [15:0] id;
        logic [15:0] rem;
        if (fifo_cnt == 0)
            return;
        id  = fifo_id[fifo_head];
        rem = fifo_rem[fifo_head];
        fifo_pop();
        fifo_push(id, rem);
    endfunction

    function automatic void demote_hp(input int i);
        fifo_push(hp_slot[i].id, hp_slot[i].rem);
        hp_slot[i].valid = 1'b0;
    endfunction

    // Advance the shadow by one transaction and return what the block should report
    function automatic sched_out_t schedule_next(input logic cmd, input logic [15:0] id,
                                                 input logic [7:0] pr,
                                                 input logic [15:0] bu);
        sched_out_t o;
        int         b;
        int         n_hp;
        o = '{1'b0, 16'd0, 1'b0, 1'b0};
        b = best_hp();
        if (cmd == prrs_pkg::CMD_ARRIVE)
        begin
            n_hp = 0;
            foreach (hp_slot[i])
                if (hp_slot[i].valid)
                    n_hp++;
            if (n_hp + fifo_cnt >= prrs_pkg::MAX_JOBS)
                o.rej = 1'b1;
            else
            begin
                // Strictly better arrival preempts a job with a partly used quantum
                if (b >= 0 && hq_left != quantum_of(hq_reg) && pr < hp_slot[b].prio)
                begin
                    demote_hp(b);
                    hq_left = quantum_of(hq_reg);
                end
                for (int i = 0; i < prrs_pkg::MAX_JOBS; i++)
                begin
                    if (!hp_slot[i].valid)
                    begin
                        hp_slot[i] = '{1'b1, id, pr, bu, next_stamp};
                        next_stamp++;
                        break;
                    end
                end
            end
        end
        else if (b >= 0)
        begin
            // A FIFO head with a partly used quantum is rotated away
            if (lq_left != quantum_of(lq_reg) && fifo_cnt != 0)
            begin
                fifo_rotate();
                lq_left = quantum_of(lq_reg);
            end
            o.run = 1'b1;
            o.id  = hp_slot[b].id;
            if (hq_left > 0)
                hq_left--;
            if (hp_slot[b].rem <= 16'd1)
            begin
                hp_slot[b].rem   = 16'd0;
                hp_slot[b].valid = 1'b0;
                o.fin            = 1'b1;
                hq_left          = quantum_of(hq_reg);
            end
            else
            begin
                hp_slot[b].rem--;
                if (hq_left == 0)
                begin
                    demote_hp(b);
                    hq_left = quantum_of(hq_reg);
                end
            end
        end
        else if (fifo_cnt != 0)
        begin
            o.run = 1'b1;
            o.id  = fifo_id[fifo_head];
            if (lq_left > 0)
                lq_left--;
            if (fifo_rem[fifo_head] <= 16'd1)
            begin
                fifo_rem[fifo_head] = 16'd0;
                fifo_pop();
                o.fin   = 1'b1;
                lq_left = quantum_of(lq_reg);
            end
            else
            begin
                fifo_rem[fifo_head]--;
                if (lq_left == 0)
                begin
                    fifo_rotate();
                    lq_left = quantum_of(lq_reg);
                end
            end
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Driver: called just after a rising edge, returns just after the
    // edge that accepted the transaction. start is left high so that the
    // next transaction can follow back to back.
    // ------------------------------------------------------------------
    task automatic issue(input job_row_t r);
        sched_out_t p;
        start        <= 1'b1;
        command      <= r.cmd;
        job_id       <= r.id;
        job_priority <= r.pr;
        job_burst    <= r.bu;
        do
            @(posedge clk);
        while (busy);
        p = schedule_next(r.cmd, r.id, r.pr, r.bu);
        if (r.chk && p != r.want)
        begin
            $error("directed row: typed outcome %p disagrees with prediction %p", r.want, p);
            n_errors++;
        end
        pending_runs.push_back(p);
        n_sent++;
    endtask

    // Wait until every outcome is back, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (prrs_pkg::MAX_JOBS + 8)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_cfg(idx, val);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: done is sampled at the edge that ends its cycle
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_out_t w;
        if (rst_n && done)
        begin
            n_results++;
            if (pending_runs.size() == 0)
            begin
                $error("result transaction with nothing expected");
                n_errors++;
            end
            else
            begin
                w = pending_runs.pop_front();
                if (ran_valid !== w.run)
                begin
                    $error("ran_valid: expected %0d, got %0d", w.run, ran_valid);
                    n_errors++;
                end
                if (ran_id !== w.id)
                begin
                    $error("ran_id: expected %h, got %h", w.id, ran_id);
                    n_errors++;
                end
                if (ran_finished !== w.fin)
                begin
                    $error("ran_finished: expected %0d, got %0d", w.fin, ran_finished);
                    n_errors++;
                end
                if (arrival_rejected !== w.rej)
                begin
                    $error("arrival_rejected: expected %0d, got %0d",
                           w.rej, arrival_rejected);
                    n_errors++;
                end
                n_finished += w.fin;
                n_rejected += w.rej;
            end
        end
    end

    // Watchdog: far above the slowest legal run, sender gaps and drains included
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > 400000)
        begin
            $display("watchdog expired, %0d outcomes outstanding", pending_runs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Random job: mostly small bursts and a narrow priority band so ties,
    // demotions and completions happen often
    function automatic job_row_t rand_job(input int arrive_pct);
        job_row_t r;
        r.chk = 1'b0;
        r.want = '{1'b0, 16'd0, 1'b0, 1'b0};
        r.cmd = ($urandom_range(99) < arrive_pct) ? prrs_pkg::CMD_ARRIVE : prrs_pkg::CMD_TICK;
        r.id  = $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(15));
        r.pr  = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
        case ($urandom_range(19))
            0:       r.bu = 16'd0;
            1:       r.bu = 16'($urandom);
            2:       r.bu = 16'hFFFF;
            default: r.bu = 16'($urandom_range(1, 9));
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        job_row_t    dir_rows[$];
        job_row_t    r;
        logic [7:0]  hq_set[6];
        logic [7:0]  lq_set[6];
        int          burst_left;
        int          arrive_pct;

        shadow_reset();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, extremes of every field, zero burst,
        // preemption of a partly run job, equal-priority order, FIFO service
        dir_rows.push_back('{prrs_pkg::CMD_TICK,   16'h0000, 8'h00, 16'h0000, 1,
                             '{0, 16'h0000, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_ARRIVE, 16'hFFFF, 8'h00, 16'h0001, 1,
                             '{0, 16'h0000, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_TICK,   16'hFFFF, 8'hFF, 16'hFFFF, 1,
                             '{1, 16'hFFFF, 1, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_TICK,   16'h0000, 8'h00, 16'h0000, 1,
                             '{0, 16'h0000, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_ARRIVE, 16'h0001, 8'hFF, 16'h0000, 1,
                             '{0, 16'h0000, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_TICK,   16'h0000, 8'h00, 16'h0000, 1,
                             '{1, 16'h0001, 1, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_ARRIVE, 16'h1234, 8'h80, 16'hFFFF, 0, '{0, 0, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_TICK,   16'h5555, 8'hAA, 16'h5555, 0, '{0, 0, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_ARRIVE, 16'h2222, 8'h10, 16'h0003, 0, '{0, 0, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_ARRIVE, 16'h3333, 8'h10, 16'h0002, 0, '{0, 0, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_ARRIVE, 16'h4444, 8'h80, 16'h0002, 0, '{0, 0, 0, 0}});
        for (int i = 0; i < 9; i++)
            dir_rows.push_back('{prrs_pkg::CMD_TICK, 16'hAAAA, 8'h55, 16'hAAAA, 0,
                                 '{0, 0, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_ARRIVE, 16'h8000, 8'h01, 16'h0005, 0, '{0, 0, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_TICK,   16'h0000, 8'h00, 16'h0000, 0, '{0, 0, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_ARRIVE, 16'h7FFF, 8'h00, 16'h0001, 0, '{0, 0, 0, 0}});
        dir_rows.push_back('{prrs_pkg::CMD_TICK,   16'h0000, 8'h00, 16'h0000, 0, '{0, 0, 0, 0}});
        foreach (dir_rows[i])
            issue(dir_rows[i]);
        drain();

        // Random phases over quantum settings, extremes and zero included
        hq_set = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd4, 8'd3};
        lq_set = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd4, 8'd2};
        for (int ph = 0; ph < 6; ph++)
        begin
            cfg_write(prrs_pkg::CFG_HIGH_QUANTUM,
                      ph == 5 ? 8'($urandom_range(1, 12)) : hq_set[ph]);
            cfg_write(prrs_pkg::CFG_LOW_QUANTUM,
                      ph == 5 ? 8'($urandom_range(1, 12)) : lq_set[ph]);
            // Alternate arrival-heavy phases (store fills, rejects) with drain-heavy ones
            arrive_pct = (ph % 2 == 0) ? 60 : 35;
            burst_left = 0;
            for (int k = 0; k < 125; k++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if (ph != 1 && $urandom_range(2) != 0)
                    begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 12))
                            @(posedge clk);
                    end
                end
                burst_left--;
                r = rand_job(arrive_pct);
                issue(r);
            end
            drain();
        end

        $display("covered %0d transactions: %0d results, %0d jobs finished, %0d arrivals rejected",
                 n_sent, n_results, n_finished, n_rejected);
        $display("six quantum settings including 0, 1 and 255 on both registers");
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
